// ===== sv/pot_pkg.sv =====
package pot_pkg;

    typedef enum logic [1:0] {
        REQ_LATCH  = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_TON = 2'd0,
        MODE_TOF = 2'd1,
        MODE_TP  = 2'd2,
        MODE_OFF = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BASE_MS     = 2'd0,
        BASE_SEC    = 2'd1,
        BASE_MIN    = 2'd2,
        BASE_UNUSED = 2'd3
    } t_base;

    typedef enum logic [1:0] {
        CFG_TIME_BASE = 2'd0,
        CFG_MODE      = 2'd1,
        CFG_PRESET    = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    localparam int unsigned CNT_W  = 16;
    localparam int unsigned PRE_W  = 10;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CNT_W-1:0] MS_STEP   = 16'd100;
    localparam logic [PRE_W-1:0] SEC_TICKS = 10'd10;
    localparam logic [PRE_W-1:0] MIN_TICKS = 10'd600;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic             timer_out;
        logic             out_pulse;
        logic [CNT_W-1:0] elapsed;
    } t_result;

endpackage

// ===== sv/plc_on_off_pulse_timer.sv =====
// Path: an accepted item enters the input register, then passes through the timer core into
// the result register when that register is free to take it.
// Throughput: one item per cycle while the receiver keeps m_axis_tready high; the timer state
// updates in one pass as the item leaves the input register, so the state loop does not limit the rate.
// Reset (i_rst_n low, synchronous): registers time_base/timer_mode/preset, timer state and
// both pipeline valids clear. A config write to an existing register also clears timer state.
module plc_on_off_pulse_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] req_type, [2] enable_level, [7:3] zero
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [0] timer_out, [1] out_pulse, [17:2] elapsed, [23:18] zero
);

    // input register stage
    logic             r_in_valid;
    logic [1:0]       r_req;
    logic             r_lvl;
    logic             out_free;
    logic             advance;
    pot_pkg::t_result res;

    // item moves into the timer core when the result register can take it
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req <= s_axis_tdata[1:0];
            r_lvl <= s_axis_tdata[2];
        end
    end

    // state update and result computation
    pot_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_go           (advance),
        .i_req_type     (r_req),
        .i_enable_level (r_lvl),
        .o_res          (res)
    );

    // result register
    pot_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (advance),
        .i_res           (res),
        .i_m_axis_tready (m_axis_tready),
        .o_free          (out_free),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tdata    (m_axis_tdata)
    );

endmodule

// ===== sv/pot_core.sv =====
// Timer state, configuration registers and the per-item update.
module pot_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_addr,
    input  logic [pot_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_go,
    input  logic [1:0]                i_req_type,
    input  logic                      i_enable_level,
    output pot_pkg::t_result          o_res
);

    logic [1:0]                r_time_base;
    logic [1:0]                r_mode;
    logic [pot_pkg::CNT_W-1:0] r_preset;

    logic [pot_pkg::CNT_W-1:0] r_cnt,   n_cnt;
    logic [pot_pkg::PRE_W-1:0] r_pre,   n_pre;
    logic                      r_en,    n_en;
    logic                      r_q,     n_q;
    logic                      r_pulse, n_pulse;

    // count step shared by up and down counting
    logic [pot_pkg::PRE_W-1:0] pre_inc;
    logic [pot_pkg::PRE_W-1:0] pre_step;
    logic [pot_pkg::CNT_W-1:0] step;
    logic [pot_pkg::CNT_W:0]   sum;
    logic [pot_pkg::CNT_W-1:0] cnt_up;
    logic [pot_pkg::CNT_W-1:0] cnt_dn;
    logic                      below;
    logic                      q_tof;

    always_comb begin
        pre_inc  = r_pre + 1'b1;
        pre_step = r_pre;
        step     = '0;
        case (pot_pkg::t_base'(r_time_base))
            pot_pkg::BASE_MS: begin
                step = pot_pkg::MS_STEP;
            end
            pot_pkg::BASE_SEC: begin
                if (pre_inc >= pot_pkg::SEC_TICKS) begin
                    step     = {{(pot_pkg::CNT_W-1){1'b0}}, 1'b1};
                    pre_step = '0;
                end else begin
                    pre_step = pre_inc;
                end
            end
            pot_pkg::BASE_MIN: begin
                if (pre_inc >= pot_pkg::MIN_TICKS) begin
                    step     = {{(pot_pkg::CNT_W-1){1'b0}}, 1'b1};
                    pre_step = '0;
                end else begin
                    pre_step = pre_inc;
                end
            end
            default: begin
                step = '0;
            end
        endcase
        sum    = {1'b0, r_cnt} + {1'b0, step};
        cnt_up = sum[pot_pkg::CNT_W] ? pot_pkg::CNT_MAX : sum[pot_pkg::CNT_W-1:0];
        cnt_dn = (r_cnt > step) ? (r_cnt - step) : '0;
        below  = r_cnt < r_preset;
        q_tof  = r_en | r_q;
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_pre   = r_pre;
        n_en    = r_en;
        n_q     = r_q;
        n_pulse = r_pulse;
        unique case (pot_pkg::t_req'(i_req_type))
            pot_pkg::REQ_LATCH: begin
                n_en = i_enable_level;
            end
            pot_pkg::REQ_TICK: begin
                unique case (pot_pkg::t_mode'(r_mode))
                    pot_pkg::MODE_TON: begin
                        n_pulse = 1'b0;
                        n_en    = 1'b0;
                        if (r_en) begin
                            if (below) begin
                                n_cnt = cnt_up;
                                n_pre = pre_step;
                            end else begin
                                n_pulse = ~r_q;
                                n_q     = 1'b1;
                            end
                        end else begin
                            n_cnt = '0;
                            n_pre = '0;
                            n_q   = 1'b0;
                        end
                    end
                    pot_pkg::MODE_TOF: begin
                        n_pulse = 1'b0;
                        n_en    = 1'b0;
                        n_q     = q_tof;
                        if (q_tof && !r_en) begin
                            if (r_cnt != '0) begin
                                n_cnt = cnt_dn;
                                n_pre = pre_step;
                            end else begin
                                n_pulse = 1'b1;
                                n_q     = 1'b0;
                            end
                        end else begin
                            n_cnt = r_preset;
                            n_pre = '0;
                        end
                    end
                    pot_pkg::MODE_TP: begin
                        n_pulse = 1'b0;
                        n_en    = 1'b0;
                        if (r_en || r_q) begin
                            if (below) begin
                                n_cnt = cnt_up;
                                n_pre = pre_step;
                                n_q   = 1'b1;
                            end else begin
                                n_pulse = r_q;
                                n_cnt   = '0;
                                n_pre   = '0;
                                n_q     = 1'b0;
                            end
                        end
                    end
                    default: begin
                        // disabled: tick has no effect
                        n_en = r_en;
                    end
                endcase
            end
            pot_pkg::REQ_CLEAR: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_comb begin
        o_res.timer_out = n_q;
        o_res.out_pulse = n_pulse;
        o_res.elapsed   = n_cnt;
    end

    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_addr != pot_pkg::CFG_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_base <= '0;
            r_mode      <= '0;
            r_preset    <= '0;
        end else if (i_cfg_we) begin
            unique case (pot_pkg::t_cfg_idx'(i_cfg_addr))
                pot_pkg::CFG_TIME_BASE: r_time_base <= i_cfg_wdata[1:0];
                pot_pkg::CFG_MODE:      r_mode      <= i_cfg_wdata[1:0];
                pot_pkg::CFG_PRESET:    r_preset    <= i_cfg_wdata[pot_pkg::CNT_W-1:0];
                default:                r_preset    <= r_preset;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_cnt   <= '0;
            r_pre   <= '0;
            r_en    <= 1'b0;
            r_q     <= 1'b0;
            r_pulse <= 1'b0;
        end else if (i_go) begin
            r_cnt   <= n_cnt;
            r_pre   <= n_pre;
            r_en    <= n_en;
            r_q     <= n_q;
            r_pulse <= n_pulse;
        end
    end

endmodule

// ===== sv/pot_out.sv =====
// Result register on the master side.
module pot_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  pot_pkg::t_result          i_res,
    input  logic                      i_m_axis_tready,
    output logic                      o_free,
    output logic                      m_axis_tvalid,
    output logic [23:0]               m_axis_tdata
);

    logic             r_valid;
    pot_pkg::t_result r_res;

    assign o_free = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {6'd0, r_res.elapsed, r_res.out_pulse, r_res.timer_out};

endmodule

// ===== tb/sv/plc_on_off_pulse_timer_test.sv =====
module plc_on_off_pulse_timer_test;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT     = 200000;
    // Receiver hold-off used once to back the pipeline up into the input.
    localparam int RX_HOLD_CYCLES  = 300;
    // Settle time before the verdict, in clock cycles.
    localparam int SETTLE_CYCLES   = 10;
    // Ticks pushed by the long run (saturation at the top of the count).
    localparam int SAT_RUN_TICKS   = 660;
    localparam int RANDOM_CHUNKS   = 8;
    localparam int CHUNK_STEPS     = 14;

    // One queued input item.
    typedef struct packed {
        pot_pkg::t_req req;
        logic          en;
    } t_timer_item;

    // ------------------------------------------------------------------
    // DUT ports, inputs driven to known values from time zero
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = 2'd0;
    logic [15:0] i_cfg_wdata   = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [1:0] req_type, [2] enable_level, [7:3] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [0] timer_out, [1] out_pulse, [17:2] elapsed

    plc_on_off_pulse_timer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Timer predictor: configuration copy and timer state
    // ------------------------------------------------------------------
    pot_pkg::t_base            cfg_base   = pot_pkg::BASE_MS;
    pot_pkg::t_mode            cfg_mode   = pot_pkg::MODE_TON;
    logic [pot_pkg::CNT_W-1:0] cfg_preset = '0;

    logic [pot_pkg::CNT_W-1:0] tm_count    = '0;
    logic [pot_pkg::PRE_W-1:0] tm_prescale = '0;
    logic                      tm_enable   = 1'b0;
    logic                      tm_q        = 1'b0;
    logic                      tm_pulse    = 1'b0;

    // Stimulus and scoreboard bookkeeping
    t_timer_item      pending_items[$];      // items not yet offered
    pot_pkg::t_result predicted_outputs[$];  // results owed by the block, oldest first
    int               pushed_count   = 0;
    int               accepted_count = 0;
    int               results_seen   = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;

    // Sender burst state
    int          tx_burst_left = 1;
    int          tx_gap_left   = 0;
    logic        tx_offer;
    t_timer_item tx_item;

    // Receiver stall pattern and hold-off
    logic [15:0] rx_pattern  = '1;
    logic [3:0]  rx_phase    = '0;
    logic        rx_hold     = 1'b0;
    logic        rx_hold_req = 1'b0;

    function automatic void clear_timer();
        tm_count    = '0;
        tm_prescale = '0;
        tm_enable   = 1'b0;
        tm_q        = 1'b0;
        tm_pulse    = 1'b0;
    endfunction

    // Prescaler advance; true when a whole count unit has gone by.
    function automatic logic unit_done(logic [pot_pkg::PRE_W-1:0] ticks);
        tm_prescale = tm_prescale + 1'b1;
        if (tm_prescale >= ticks) begin
            tm_prescale = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Count change for one tick under the current time base.
    function automatic logic [pot_pkg::CNT_W-1:0] base_amount();
        logic [pot_pkg::CNT_W-1:0] amount;
        amount = '0;
        case (cfg_base)
            pot_pkg::BASE_MS:  amount = pot_pkg::MS_STEP;
            pot_pkg::BASE_SEC: amount[0] = unit_done(pot_pkg::SEC_TICKS);
            pot_pkg::BASE_MIN: amount[0] = unit_done(pot_pkg::MIN_TICKS);
            default:           amount = '0;   // unused base: count and prescaler hold
        endcase
        return amount;
    endfunction

    function automatic void count_up();
        logic [pot_pkg::CNT_W:0] sum;
        sum = {1'b0, tm_count} + {1'b0, base_amount()};
        tm_count = sum[pot_pkg::CNT_W] ? pot_pkg::CNT_MAX : sum[pot_pkg::CNT_W-1:0];
    endfunction

    function automatic void count_down();
        logic [pot_pkg::CNT_W-1:0] amount;
        amount = base_amount();
        tm_count = (tm_count > amount) ? tm_count - amount : '0;
    endfunction

    function automatic void timer_tick();
        case (cfg_mode)
            pot_pkg::MODE_TON: begin
                tm_pulse = 1'b0;
                if (tm_enable) begin
                    if (tm_count < cfg_preset) begin
                        count_up();
                    end else begin
                        tm_pulse = !tm_q;   // rising edge of Q
                        tm_q     = 1'b1;
                    end
                end else begin
                    tm_count    = '0;
                    tm_prescale = '0;
                    tm_q        = 1'b0;
                end
                tm_enable = 1'b0;
            end
            pot_pkg::MODE_TOF: begin
                tm_pulse = 1'b0;
                if (tm_enable) tm_q = 1'b1;
                if (tm_q && !tm_enable) begin
                    if (tm_count != '0) begin
                        count_down();
                    end else begin
                        tm_pulse = 1'b1;    // falling edge of Q
                        tm_q     = 1'b0;
                    end
                end else begin
                    tm_count    = cfg_preset;
                    tm_prescale = '0;
                end
                tm_enable = 1'b0;
            end
            pot_pkg::MODE_TP: begin
                tm_pulse = 1'b0;
                if (tm_enable || tm_q) begin
                    if (tm_count < cfg_preset) begin
                        count_up();
                        tm_q = 1'b1;
                    end else begin
                        tm_pulse    = tm_q; // end of pulse
                        tm_count    = '0;
                        tm_prescale = '0;
                        tm_q        = 1'b0;
                    end
                end
                tm_enable = 1'b0;
            end
            default: ;  // disabled: tick changes nothing, latch kept
        endcase
    endfunction

    // Applies one item to the predictor, returns the result it should give.
    function automatic pot_pkg::t_result timer_step(pot_pkg::t_req req, logic en);
        pot_pkg::t_result res;
        case (req)
            pot_pkg::REQ_LATCH: tm_enable = en;
            pot_pkg::REQ_TICK:  timer_tick();
            pot_pkg::REQ_CLEAR: tm_count = '0;
            default: ;
        endcase
        res.timer_out = tm_q;
        res.out_pulse = tm_pulse;
        res.elapsed   = tm_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s = %0d, predicted %0d",
                 results_seen, what, got, want);
    endtask

    task automatic check_result(logic [23:0] data);
        pot_pkg::t_result want;
        results_seen++;
        if (predicted_outputs.size() == 0) begin
            report_mismatch("unexpected result, tdata", data, 0);
            return;
        end
        want = predicted_outputs.pop_front();
        if (data[0] !== want.timer_out)
            report_mismatch("timer_out", data[0], want.timer_out);
        if (data[1] !== want.out_pulse)
            report_mismatch("out_pulse", data[1], want.out_pulse);
        if (data[17:2] !== want.elapsed)
            report_mismatch("elapsed", data[17:2], want.elapsed);
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers queued items in bursts with random gaps. Prediction is
    // made at the edge where the block takes the item.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_burst_left = 1;
            tx_gap_left   = 0;
        end else begin
            tx_offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_outputs.push_back(
                    timer_step(pot_pkg::t_req'(s_axis_tdata[1:0]), s_axis_tdata[2]));
                accepted_count++;
                tx_offer = 1'b0;
            end
            if (!tx_offer) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                end else if (pending_items.size() > 0) begin
                    tx_item = pending_items.pop_front();
                    s_axis_tdata <= {5'b0, tx_item.en, tx_item.req};
                    tx_offer = 1'b1;
                    tx_burst_left--;
                    if (tx_burst_left <= 0) begin
                        // quarter of bursts run straight into the next one
                        tx_burst_left = $urandom_range(1, 40);
                        tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_axis_tvalid <= tx_offer;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result; tready follows a rotating 16-bit
    // pattern reloaded when the phase counter wraps (all-ready, random, or mostly stalled).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_pattern = '1;
            rx_phase   = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
            if (rx_phase == '0) begin
                case ($urandom_range(0, 2))
                    0:       rx_pattern = '1;
                    1:       rx_pattern = 16'($urandom);
                    default: rx_pattern = 16'($urandom & $urandom);
                endcase
            end else begin
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
            rx_phase = rx_phase + 1'b1;
            m_axis_tready <= rx_pattern[0] && !rx_hold;
        end
    end

    // One long receiver hold-off, started on request; the sender keeps going.
    initial begin
        wait (rx_hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(pot_pkg::t_req req, logic en);
        t_timer_item it;
        it.req = req;
        it.en  = en;
        pending_items.push_back(it);
        pushed_count++;
    endtask

    // Sender pause: everything offered taken and every result back.
    task automatic wait_results_drained();
        while (accepted_count != pushed_count || predicted_outputs.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write; only called with the block idle. A write to a real
    // register clears timer state, the unused index does nothing.
    task automatic write_reg(pot_pkg::t_cfg_idx idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        case (idx)
            pot_pkg::CFG_TIME_BASE: begin
                cfg_base = pot_pkg::t_base'(value[1:0]);
                clear_timer();
            end
            pot_pkg::CFG_MODE: begin
                cfg_mode = pot_pkg::t_mode'(value[1:0]);
                clear_timer();
            end
            pot_pkg::CFG_PRESET: begin
                cfg_preset = value;
                clear_timer();
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_timer(pot_pkg::t_base base, pot_pkg::t_mode mode,
                                 logic [15:0] preset_val);
        write_reg(pot_pkg::CFG_TIME_BASE, {14'd0, base});
        write_reg(pot_pkg::CFG_MODE, {14'd0, mode});
        write_reg(pot_pkg::CFG_PRESET, preset_val);
    endtask

    // Random setting; presets kept reachable for the chosen base.
    task automatic pick_random_timer();
        int             roll;
        pot_pkg::t_base base;
        logic [15:0]    pv;
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            base = pot_pkg::BASE_MS;
            pv   = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 1600));
        end else if (roll < 8) begin
            base = pot_pkg::BASE_SEC;
            pv   = 16'($urandom_range(0, 2));
        end else if (roll < 9) begin
            base = pot_pkg::BASE_MIN;
            pv   = 16'($urandom_range(0, 1));
        end else begin
            base = pot_pkg::BASE_UNUSED;
            pv   = 16'($urandom_range(0, 5));
        end
        program_timer(base, pot_pkg::t_mode'($urandom_range(0, 3)), pv);
    endtask

    // Mostly "latch then tick" pairs following a slowly flipping input
    // level, so timers actually run up to the preset; the rest is single
    // ticks, stray latches, clears and unused requests.
    task automatic push_random_run(int steps);
        logic level;
        int   roll;
        int   pair_pct;
        level    = 1'b1;
        pair_pct = (cfg_mode == pot_pkg::MODE_TON) ? 90 : 55;
        for (int s = 0; s < steps; s++) begin
            if ($urandom_range(0, 19) == 0) level = ~level;
            roll = $urandom_range(0, 99);
            if (roll < pair_pct) begin
                push_item(pot_pkg::REQ_LATCH, ($urandom_range(0, 9) == 0) ? ~level : level);
                push_item(pot_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
            end else if (roll < pair_pct + (96 - pair_pct) / 2) begin
                push_item(pot_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
            end else if (roll < 92) begin
                push_item(pot_pkg::REQ_LATCH, 1'($urandom_range(0, 1)));
            end else if (roll < 97) begin
                push_item(pot_pkg::REQ_CLEAR, 1'($urandom_range(0, 1)));
            end else begin
                push_item(pot_pkg::REQ_UNUSED, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Pulse-mode long run: one start latch, then ticks with a little noise
    // that cannot restart the count while Q is high.
    task automatic push_pulse_run(int ticks);
        int done;
        int roll;
        done = 0;
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        while (done < ticks) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                push_item(pot_pkg::REQ_LATCH, 1'($urandom_range(0, 1)));
            end else if (roll == 1) begin
                push_item(pot_pkg::REQ_UNUSED, 1'($urandom_range(0, 1)));
            end else begin
                push_item(pot_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // On-delay, ms base: count up, Q rises with a pulse, Q holds, a
        // tick without enable drops it; unused request, latch, clear.
        program_timer(pot_pkg::BASE_MS, pot_pkg::MODE_TON, 16'd150);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_UNUSED, 1'b1);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_CLEAR, 1'b1);
        wait_results_drained();

        // Off-delay: load, count down past zero (floors at 0), falling pulse,
        // enable bit on a tick is ignored.
        program_timer(pot_pkg::BASE_MS, pot_pkg::MODE_TOF, 16'd150);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_TICK, 1'b1);
        wait_results_drained();

        // Disabled mode keeps the latch across ticks.
        program_timer(pot_pkg::BASE_MS, pot_pkg::MODE_OFF, 16'd0);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        push_item(pot_pkg::REQ_TICK, 1'b1);
        wait_results_drained();

        // Unused time base: counting tick leaves the count alone.
        program_timer(pot_pkg::BASE_UNUSED, pot_pkg::MODE_TON, 16'd5);
        push_item(pot_pkg::REQ_LATCH, 1'b1);
        push_item(pot_pkg::REQ_TICK, 1'b0);
        wait_results_drained();

        // Count saturating at the top (pulse mode, largest preset), with the
        // receiver held off long enough to stall the input side.
        program_timer(pot_pkg::BASE_MS, pot_pkg::MODE_TP, 16'hFFFF);
        rx_hold_req <= 1'b1;
        push_pulse_run(SAT_RUN_TICKS);
        wait_results_drained();

        // Random settings and sequences, draining between chunks.
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            if (chunk == 0) begin
                program_timer(pot_pkg::BASE_SEC, pot_pkg::MODE_TON, 16'd1);
            end else if (chunk == 5) begin
                // unused register index: setting and state must survive
                write_reg(pot_pkg::CFG_NONE, 16'($urandom));
            end else if (chunk == 6) begin
                write_reg(pot_pkg::CFG_PRESET, 16'($urandom_range(0, 800)));
            end else begin
                pick_random_timer();
            end
            push_random_run(CHUNK_STEPS);
            wait_results_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== plc_on_off_pulse_timer.f =====
sv/pot_pkg.sv
sv/pot_core.sv
sv/pot_out.sv
sv/plc_on_off_pulse_timer.sv
tb/sv/plc_on_off_pulse_timer_test.sv
